// ===== design/assert_macros.svh =====
// Assertion macros shared by the solver RTL.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent on one edge implies consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tds_pkg.sv =====
// Shared types and constants for the tridiagonal solver.
// No dependencies; used by tds_div and tridiagonal_system_solver.
package tds_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int DVD_W     = DATA_W + FRAC_BITS;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_PIVOT = 2'd1;
  localparam logic [1:0] ERR_ROWS  = 2'd2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Divider status returned to the sequencer
  typedef struct packed {
    logic                     done;
    logic                     zero;
    logic signed [DATA_W-1:0] quo;
  } div_res_t;

endpackage

// ===== design/tds_div.sv =====
// Iterative signed fixed-point divider, one quotient bit per cycle.
// Depends on tds_pkg.
module tds_div import tds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output div_res_t                 res
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic              fin;
  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [DATA_W-1:0] dmag;
  logic [DATA_W-1:0] rem;
  logic [DVD_W-1:0]  dvd;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [DATA_W-1:0] nmag_in;
  logic [DATA_W-1:0] dmag_in;
  logic              done_r;
  logic              zero_r;
  logic signed [DATA_W-1:0] quo_r;

  // Pack the status for the sequencer
  assign res = {done_r, zero_r, quo_r};

  // Magnitudes of the operands
  assign nmag_in = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign dmag_in = den[DATA_W-1] ? (~den + 1'b1) : den;

  // Restoring step
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  // Control: start, iterate, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fin    <= 1'b0;
      done_r <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin    <= 1'b0;
      if (start) begin
        zero_r <= 1'b0;
        if (den == '0) begin
          done_r <= 1'b1;
          zero_r <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[DATA_W-1] ^ den[DATA_W-1];
      dmag  <= dmag_in;
      rem   <= '0;
      dvd   <= {nmag_in, {FRAC_BITS{1'b0}}};
      steps <= STEP_W'(DVD_W);
      quo_r <= (num[DATA_W-1]) ? SAT_MIN : SAT_MAX;
    end else if (busy) begin
      rem   <= ge ? DATA_W'(rem_sh - {1'b0, dmag}) : rem_sh[DATA_W-1:0];
      dvd   <= {dvd[DVD_W-2:0], ge};
      steps <= steps - 1'b1;
    end else if (fin) begin
      // Apply sign and saturate
      if (neg) begin
        if (dvd > DVD_W'({1'b1, {(DATA_W-1){1'b0}}})) quo_r <= SAT_MIN;
        else quo_r <= ~dvd[DATA_W-1:0] + 1'b1;
      end else begin
        if (dvd > DVD_W'(SAT_MAX)) quo_r <= SAT_MAX;
        else quo_r <= dvd[DATA_W-1:0];
      end
    end
  end

endmodule

// ===== design/tridiagonal_system_solver.sv =====
// Thomas-algorithm tridiagonal solver, signed fixed point.
// Row 0 takes one division; later rows take two divisions (48 quotient bits each)
// on the shared divider plus two multiply-subtract passes on one multiplier.
// The back sweep reads the stores, subtracts and holds each result until out_ready.
// Synchronous reset clears control, counters and error; stores stay undefined.
module tridiagonal_system_solver import tds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] sub_diag,
  input  logic signed [DATA_W-1:0] main_diag,
  input  logic signed [DATA_W-1:0] super_diag,
  input  logic signed [DATA_W-1:0] rhs,
  input  logic                     last_row,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] solution_value,
  output logic [IDX_W-1:0]         row_index,
  output logic                     last_result,
  output logic [1:0]               error_code
);

`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV0    = 4'd1;
  localparam logic [3:0] S_GWAIT   = 4'd2;
  localparam logic [3:0] S_MULAG   = 4'd3;
  localparam logic [3:0] S_PIV     = 4'd4;
  localparam logic [3:0] S_MULAU   = 4'd5;
  localparam logic [3:0] S_NUM     = 4'd6;
  localparam logic [3:0] S_UWAIT   = 4'd7;
  localparam logic [3:0] S_ROWEND  = 4'd8;
  localparam logic [3:0] S_BSRD    = 4'd9;
  localparam logic [3:0] S_BSDATA  = 4'd10;
  localparam logic [3:0] S_BSSUB   = 4'd11;
  localparam logic [3:0] S_OUTWAIT = 4'd12;

  logic [3:0]               state;
  logic [CNT_W-1:0]         count;
  logic [1:0]               err;
  logic signed [DATA_W-1:0] a_r, b_r, c_r, r_r;
  logic                     last_r;
  logic signed [DATA_W-1:0] pivot, prev_c, g_r, u_last, u_next;
  logic signed [2*DATA_W-1:0] mul_p;
  logic signed [DATA_W-1:0] mul_x, mul_y;
  logic [IDX_W-1:0]         bs_j;
  logic                     bs_first;

  logic                     div_start;
  logic signed [DATA_W-1:0] div_num, div_den;
  div_res_t                 div_res;

  logic signed [DATA_W-1:0] gamma_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] psol_mem  [MAX_ROWS];
  logic signed [DATA_W-1:0] gamma_rd, psol_rd;
  logic                     mem_we_g, mem_we_u;
  logic signed [DATA_W-1:0] sub_a, sub_res;

  // Saturating x - (p >>> FRAC_BITS)
  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0]   x,
    input logic signed [2*DATA_W-1:0] p
  );
    logic signed [2*DATA_W:0] d;
    d = (2*DATA_W+1)'(x) - (2*DATA_W+1)'(p >>> FRAC_BITS);
    if (d > (2*DATA_W+1)'(SAT_MAX)) return SAT_MAX;
    if (d < (2*DATA_W+1)'(SAT_MIN)) return SAT_MIN;
    return d[DATA_W-1:0];
  endfunction

  tds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  assign in_ready = (state == S_IDLE);

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_MULAG:  begin mul_x = a_r;      mul_y = g_r;    end
      S_MULAU:  begin mul_x = a_r;      mul_y = u_last; end
      default:  begin mul_x = gamma_rd; mul_y = u_next; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_x * mul_y;
  end

  // Shared saturating subtract
  always_comb begin
    case (state)
      S_PIV:   sub_a = b_r;
      S_NUM:   sub_a = r_r;
      default: sub_a = psol_rd;
    endcase
    sub_res = sat_sub(sub_a, mul_p);
  end

  // Stores: write during elimination, registered read for the back sweep
  assign mem_we_g = (state == S_GWAIT) && div_res.done;
  assign mem_we_u = ((state == S_UWAIT) || (state == S_DIV0)) && div_res.done;

  always_ff @(posedge clk) begin
    if (mem_we_g) gamma_mem[count[IDX_W-1:0]] <= div_res.quo;
    if (mem_we_u) psol_mem[count[IDX_W-1:0]]  <= div_res.quo;
    psol_rd  <= psol_mem[bs_j];
    gamma_rd <= gamma_mem[bs_j + 1'b1];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= ERR_OK;
      pivot     <= '0;
      prev_c    <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      bs_j      <= '0;
      bs_first  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_r    <= sub_diag;
            b_r    <= main_diag;
            c_r    <= super_diag;
            r_r    <= rhs;
            last_r <= last_row;
            if (count == CNT_W'(MAX_ROWS)) begin
              // Drop the row, flag it, still solve on a last mark
              err <= ERR_ROWS;
              if (last_row) begin
                bs_j     <= IDX_W'(count - 1'b1);
                bs_first <= 1'b1;
                state    <= S_BSRD;
              end
            end else if (count == '0) begin
              pivot     <= main_diag;
              div_num   <= rhs;
              div_den   <= main_diag;
              div_start <= 1'b1;
              state     <= S_DIV0;
            end else begin
              div_num   <= prev_c;
              div_den   <= pivot;
              div_start <= 1'b1;
              state     <= S_GWAIT;
            end
          end
        end
        S_DIV0: begin
          if (div_res.done) begin
            u_last <= div_res.quo;
            if (div_res.zero && err == ERR_OK) err <= ERR_PIVOT;
            state <= S_ROWEND;
          end
        end
        S_GWAIT: begin
          if (div_res.done) begin
            g_r <= div_res.quo;
            if (div_res.zero && err == ERR_OK) err <= ERR_PIVOT;
            state <= S_MULAG;
          end
        end
        S_MULAG: state <= S_PIV;
        S_PIV: begin
          pivot <= sub_res;
          state <= S_MULAU;
        end
        S_MULAU: state <= S_NUM;
        S_NUM: begin
          div_num   <= sub_res;
          div_den   <= pivot;
          div_start <= 1'b1;
          state     <= S_UWAIT;
        end
        S_UWAIT: begin
          if (div_res.done) begin
            u_last <= div_res.quo;
            if (div_res.zero && err == ERR_OK) err <= ERR_PIVOT;
            state <= S_ROWEND;
          end
        end
        S_ROWEND: begin
          prev_c <= c_r;
          count  <= count + 1'b1;
          if (last_r) begin
            bs_j     <= count[IDX_W-1:0];
            bs_first <= 1'b1;
            state    <= S_BSRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BSRD: state <= S_BSDATA;
        S_BSDATA: begin
          if (bs_first) begin
            solution_value <= psol_rd;
            u_next         <= psol_rd;
            row_index      <= bs_j;
            last_result    <= (bs_j == '0);
            error_code     <= err;
            out_valid      <= 1'b1;
            state          <= S_OUTWAIT;
          end else begin
            state <= S_BSSUB;
          end
        end
        S_BSSUB: begin
          solution_value <= sub_res;
          u_next         <= sub_res;
          row_index      <= bs_j;
          last_result    <= (bs_j == '0);
          error_code     <= err;
          out_valid      <= 1'b1;
          state          <= S_OUTWAIT;
        end
        S_OUTWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            bs_first  <= 1'b0;
            if (bs_j == '0) begin
              // End of run: clear the elimination state
              count  <= '0;
              pivot  <= '0;
              prev_c <= '0;
              err    <= ERR_OK;
              state  <= S_IDLE;
            end else begin
              bs_j  <= bs_j - 1'b1;
              state <= S_BSRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_out_in_wait, clk, rst, !out_valid || state == S_OUTWAIT)
  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(MAX_ROWS))
  `ASSERT_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid))
  `ASSERT_NEXT(a_run_clears, clk, rst, out_valid && out_ready && last_result, count == '0 && err == ERR_OK)

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for the tridiagonal solver: queued row driver, clocked monitor
// and a fixed-point Thomas-algorithm predictor. Depends on tds_pkg and the solver RTL.
`timescale 1ns / 100ps
module tb import tds_pkg::*;;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] r;
    logic                     last;
  } row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic [IDX_W-1:0]         idx;
    logic                     lst;
    logic [1:0]               err;
  } soln_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] sub_diag = '0, main_diag = '0, super_diag = '0, rhs = '0;
  logic last_row = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] solution_value;
  logic [IDX_W-1:0] row_index;
  logic last_result;
  logic [1:0] error_code;

  tridiagonal_system_solver u_dut (.*);

  always #2 clk = ~clk;

  row_t  pending_rows[$];
  soln_t expected_solns[$];
  int    errors = 0;
  bit    stim_done = 0;
  bit    hold_pause = 0;     // sender waits for drain
  int    long_stall = 0;     // receiver hold-off cycles left
  bit    stall_done = 0;
  int    idle_cycles = 0;

  // predictor state
  logic signed [DATA_W-1:0] gam[MAX_ROWS];
  logic signed [DATA_W-1:0] part[MAX_ROWS];
  logic signed [DATA_W-1:0] pivot, prev_c;
  int                       nrows;
  logic [1:0]               err_st;

  function automatic logic signed [DATA_W-1:0] clamp(longint v);
    if (v > 64'sd2147483647) return SAT_MAX;
    if (v < -64'sd2147483648) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  // floor-shifted product, kept wide
  function automatic longint fx_mul(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_div(logic signed [DATA_W-1:0] n,
                                                      logic signed [DATA_W-1:0] d);
    longint q;
    if (d == 0) begin
      if (err_st < ERR_PIVOT) err_st = ERR_PIVOT;
      return (n >= 0) ? SAT_MAX : SAT_MIN;
    end
    q = (longint'(n) * (64'sd1 << FRAC_BITS)) / longint'(d);
    return clamp(q);
  endfunction

  // forward elimination, back sweep on the last row
  task automatic solve_row(row_t rw);
    logic signed [DATA_W-1:0] g, num;
    soln_t s;
    if (nrows < MAX_ROWS) begin
      if (nrows == 0) begin
        pivot = rw.b;
        part[0] = fx_div(rw.r, rw.b);
      end else begin
        g = fx_div(prev_c, pivot);
        gam[nrows] = g;
        pivot = clamp(longint'(rw.b) - fx_mul(rw.a, g));
        num = clamp(longint'(rw.r) - fx_mul(rw.a, part[nrows-1]));
        part[nrows] = fx_div(num, pivot);
      end
      prev_c = rw.c;
      nrows++;
    end else err_st = ERR_ROWS;
    if (!rw.last) return;
    for (int j = nrows - 2; j >= 0; j--)
      part[j] = clamp(longint'(part[j]) - fx_mul(gam[j+1], part[j+1]));
    for (int k = nrows - 1; k >= 0; k--) begin
      s.val = part[k]; s.idx = k[IDX_W-1:0]; s.lst = (k == 0); s.err = err_st;
      expected_solns.push_back(s);
    end
    nrows = 0; pivot = 0; prev_c = 0; err_st = ERR_OK;
  endtask

  function automatic logic signed [DATA_W-1:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return SAT_MAX;
      2: return SAT_MIN;
      3: return 0;
      default: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
    endcase
  endfunction

  // diagonally dominant row with random content
  function automatic row_t good_row(bit last);
    row_t rw;
    rw.a = $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
    rw.c = $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
    rw.b = $signed(32'($urandom_range(32'h0003_0000, 32'h0020_0000)));
    if ($urandom_range(0, 1)) rw.b = -rw.b;
    rw.r = rnd_val();
    rw.last = last;
    return rw;
  endfunction

  function automatic row_t mk(logic signed [DATA_W-1:0] a, b, c, r, bit last);
    row_t rw;
    rw.a = a; rw.b = b; rw.c = c; rw.r = r; rw.last = last;
    return rw;
  endfunction

  // stimulus: directed systems then random ones
  initial begin
    int len, total;
    row_t rw;
    pivot = 0; prev_c = 0; nrows = 0; err_st = ERR_OK;
    // single row, extremes, zero pivot both signs
    pending_rows.push_back(mk(SAT_MIN, 32'sh0002_0000, SAT_MAX, 32'sh0003_0000, 1));
    pending_rows.push_back(mk(0, 0, 0, 32'sh0001_0000, 1));
    pending_rows.push_back(mk(0, 0, 0, -32'sh0001_0000, 1));
    pending_rows.push_back(mk(0, 0, 0, 0, 1));
    pending_rows.push_back(mk(0, SAT_MIN, 0, SAT_MAX, 1));
    pending_rows.push_back(mk(0, 32'sh0000_0001, 0, SAT_MAX, 1));
    // three-row system with all-ones and extreme mixes
    pending_rows.push_back(mk(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, 0));
    pending_rows.push_back(mk(SAT_MIN, 32'shFFFF_FFFF, SAT_MAX, SAT_MAX, 0));
    pending_rows.push_back(mk(SAT_MAX, SAT_MIN, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1));
    // zero pivot mid system (c0 = b0*b1/a1 gives pivot 0)
    pending_rows.push_back(mk(0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0));
    pending_rows.push_back(mk(32'sh0001_0000, 32'sh0001_0000, 0, 32'sh0002_0000, 1));
    total = 11;
    // overflow: 66 rows, last flagged after capacity
    for (int i = 0; i < 66; i++) pending_rows.push_back(good_row(i == 65));
    total += 66;
    while (total < 310) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      if (len > 310 - total) len = 310 - total;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          rw = mk(rnd_val(), rnd_val(), rnd_val(), rnd_val(), i == len - 1);
        else rw = good_row(i == len - 1);
        pending_rows.push_back(rw);
      end
      total += len;
    end
  end

  // reset
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: bursts and gaps; one pause for full drain
  int  burst = 0, gap = 0, sent = 0;
  bit  paused_once = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        solve_row({sub_diag, main_diag, super_diag, rhs, last_row});
        sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (!paused_once && sent >= 120 && expected_solns.size() != 0) begin
          hold_pause = 1; paused_once = 1;
        end
        if (hold_pause && expected_solns.size() == 0) hold_pause = 0;
        if (gap > 0) gap--;
        if (hold_pause || gap > 0 || pending_rows.size() == 0) begin
          in_valid <= 1'b0;
          if (pending_rows.size() == 0 && !(in_valid && !in_ready)) stim_done = 1;
        end else begin
          {sub_diag, main_diag, super_diag, rhs, last_row} <= pending_rows.pop_front();
          in_valid <= 1'b1;
          if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else burst--;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off once results flow
  int rx_phase = 0;
  always @(posedge clk) begin
    rx_phase++;
    if (!stall_done && out_valid && sent > 80) begin
      long_stall = 4000;
      stall_done = 1;
    end
    if (long_stall > 0) begin
      long_stall--;
      out_ready <= 1'b0;
    end else if ((rx_phase / 200) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    soln_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_solns.size() == 0) begin
        $display("%0t unexpected result: value %h row %0d", $time, solution_value, row_index);
        errors++;
      end else begin
        e = expected_solns.pop_front();
        if (e.val !== solution_value) begin
          $display("%0t value row %0d: expected %h actual %h", $time, e.idx, e.val,
                   solution_value);
          errors++;
        end
        if (e.idx !== row_index) begin
          $display("%0t row_index: expected %0d actual %0d", $time, e.idx, row_index);
          errors++;
        end
        if (e.lst !== last_result) begin
          $display("%0t last_result: expected %b actual %b", $time, e.lst, last_result);
          errors++;
        end
        if (e.err !== error_code) begin
          $display("%0t error_code: expected %0d actual %0d", $time, e.err, error_code);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_solns.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tds_pkg.sv
design/tds_div.sv
design/tridiagonal_system_solver.sv
sim/tb.sv
